/* hdl/mbce_pkg.sv */
// Shared types and constants for the multi-burst clap envelope block.
// Used by the channel interfaces, the register file, the sequencer and the multiplier.
// Depends on nothing.
package mbce_pkg;

	localparam int SAMPLE_W = 16;
	localparam int LEVEL_W  = 32;
	localparam int RATE_W   = 31;
	localparam int PROD_W   = 2 * SAMPLE_W;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [LEVEL_W-1:0] LEVEL_START = 32'h7fff_0000;
	localparam logic [LEVEL_W-1:0] LEVEL_FLOOR = 32'h0000_ffff;

	localparam logic [2:0] STAGE_FIRST = 3'd0;
	localparam logic [2:0] STAGE_TAIL  = 3'd6;
	localparam logic [2:0] STAGE_IDLE  = 3'd7;

	// floor(x / 3) for x below 2**31 equals (x * TAIL_RECIP) >> TAIL_SHIFT.
	localparam logic [31:0] TAIL_RECIP = 32'haaaa_aaab;
	localparam int          TAIL_SHIFT = 33;
	localparam int          TAIL_PROD_W = RATE_W + 32;

	localparam logic REQ_SAMPLES = 1'b0;
	localparam logic REQ_TRIGGER = 1'b1;

	localparam logic REG_BURST = 1'b0;
	localparam logic REG_GAP   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ_A,
		ST_SC_A,
		ST_SQ_B,
		ST_SC_B,
		ST_OUT
	} seq_state_t;

	typedef struct packed {
		logic [RATE_W-1:0] burst;
		logic [RATE_W-1:0] gap;
		logic [RATE_W-1:0] tail;
	} rates_t;

	typedef struct packed {
		logic                       en;
		logic signed [SAMPLE_W-1:0] op_a;
		logic signed [SAMPLE_W-1:0] op_b;
	} mul_req_t;

endpackage

/* hdl/mbce_if.sv */
// Valid/ready channel interfaces for the clap envelope block.
// mbce_req_if carries requests in, mbce_rsp_if carries enveloped sample pairs out.
// Depends on mbce_pkg.
interface mbce_req_if
	import mbce_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic                       req_type;
	logic signed [SAMPLE_W-1:0] sample_first;
	logic signed [SAMPLE_W-1:0] sample_second;

	modport source (output valid, output req_type, output sample_first,
		output sample_second, input ready);
	modport sink (input valid, input req_type, input sample_first,
		input sample_second, output ready);
endinterface

interface mbce_rsp_if
	import mbce_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] out_first;
	logic signed [SAMPLE_W-1:0] out_second;

	modport source (output valid, output out_first, output out_second, input ready);
	modport sink (input valid, input out_first, input out_second, output ready);
endinterface

/* hdl/mbce_regs.sv */
// APB configuration registers: burst rate and gap rate, plus the derived tail rate.
// The tail rate is one third of the burst rate, computed as the register is written.
// Depends on mbce_pkg.
module mbce_regs
	import mbce_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output rates_t             rates
);

	logic                   wr_en;
	logic [TAIL_PROD_W-1:0] tail_prod;
	logic [RATE_W-1:0]      burst_q;
	logic [RATE_W-1:0]      gap_q;
	logic [RATE_W-1:0]      tail_q;

	assign pready    = 1'b1;
	assign wr_en     = psel && penable && pwrite;
	assign tail_prod = TAIL_PROD_W'(pwdata[RATE_W-1:0]) * TAIL_PROD_W'(TAIL_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_q <= '0;
			gap_q   <= '0;
			tail_q  <= '0;
		end else if (wr_en) begin
			case (paddr[2])
				REG_BURST: begin
					burst_q <= pwdata[RATE_W-1:0];
					tail_q  <= RATE_W'(tail_prod >> TAIL_SHIFT);
				end
				REG_GAP: begin
					gap_q <= pwdata[RATE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_BURST: prdata = PDATA_W'(burst_q);
			REG_GAP:   prdata = PDATA_W'(gap_q);
			default:   prdata = '0;
		endcase
	end

	assign rates.burst = burst_q;
	assign rates.gap   = gap_q;
	assign rates.tail  = tail_q;

endmodule

/* hdl/mbce_mul.sv */
// Shared signed 16 by 16 multiplier with a registered product.
// Used for both the level square and the sample scaling of every sample.
// Depends on mbce_pkg.
module mbce_mul
	import mbce_pkg::*;
(
	input  logic                     clk,
	input  mul_req_t                 mul_req,
	output logic signed [PROD_W-1:0] prod
);

	logic signed [PROD_W-1:0] prod_full;
	logic signed [PROD_W-1:0] prod_q;

	assign prod_full = $signed(mul_req.op_a) * $signed(mul_req.op_b);

	always_ff @(posedge clk) begin
		if (mul_req.en) begin
			prod_q <= prod_full;
		end
	end

	assign prod = prod_q;

endmodule

/* hdl/mbce_ctrl.sv */
// Sequencer for the clap envelope: level and stage state, four passes through the
// shared multiplier per sample pair, and the output register.
// Depends on mbce_pkg and the channel interfaces.
module mbce_ctrl
	import mbce_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	mbce_req_if.sink                 req,
	mbce_rsp_if.source               rsp,
	input  rates_t                   rates,
	output mul_req_t                 mul_req,
	input  logic signed [PROD_W-1:0] prod
);

	seq_state_t                 state_q;
	seq_state_t                 state_next;
	logic [2:0]                 stage_q;
	logic [LEVEL_W-1:0]         level_q;
	logic signed [SAMPLE_W-1:0] samp_a_q;
	logic signed [SAMPLE_W-1:0] samp_b_q;
	logic signed [SAMPLE_W-1:0] first_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_first_q;
	logic signed [SAMPLE_W-1:0] out_second_q;

	logic                       accept;
	logic                       out_free;
	logic                       done;
	logic                       audible;
	logic                       below_floor;
	logic [RATE_W-1:0]          rate;
	logic [LEVEL_W-1:0]         rate_ext;
	logic signed [SAMPLE_W-1:0] level_hi;
	logic signed [SAMPLE_W-1:0] gain;

	assign accept      = req.valid && req.ready;
	assign out_free    = !out_valid_q || rsp.ready;
	assign done        = (state_q == ST_OUT) && out_free;
	assign audible     = !stage_q[0] || (stage_q == STAGE_TAIL);
	assign below_floor = $signed(level_q) < $signed(LEVEL_FLOOR);
	assign rate_ext    = LEVEL_W'(rate);
	assign level_hi    = level_q[LEVEL_W-1 -: SAMPLE_W];
	assign gain        = prod[PROD_W-2 -: SAMPLE_W];

	always_comb begin
		if (stage_q == STAGE_TAIL) begin
			rate = rates.tail;
		end else if (stage_q[0]) begin
			rate = rates.gap;
		end else begin
			rate = rates.burst;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && req.req_type == REQ_SAMPLES) begin
					state_next = ST_SQ_A;
				end
			end
			ST_SQ_A: state_next = ST_SC_A;
			ST_SC_A: state_next = ST_SQ_B;
			ST_SQ_B: state_next = ST_SC_B;
			ST_SC_B: state_next = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready    = 1'b0;
		mul_req.en   = 1'b0;
		mul_req.op_a = '0;
		mul_req.op_b = '0;
		case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_SQ_A, ST_SQ_B: begin
				mul_req.en   = 1'b1;
				mul_req.op_a = level_hi;
				mul_req.op_b = level_hi;
			end
			ST_SC_A: begin
				mul_req.en   = 1'b1;
				mul_req.op_a = gain;
				mul_req.op_b = samp_a_q;
			end
			ST_SC_B: begin
				mul_req.en   = 1'b1;
				mul_req.op_a = gain;
				mul_req.op_b = samp_b_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			stage_q <= STAGE_IDLE;
		end else if (accept) begin
			if (req.req_type == REQ_TRIGGER) begin
				level_q <= LEVEL_START;
				stage_q <= STAGE_FIRST;
			end else begin
				level_q <= level_q - rate_ext;
			end
		end else if (state_q == ST_SQ_A) begin
			level_q <= level_q - rate_ext;
		end else if (done) begin
			if (stage_q == STAGE_IDLE) begin
				level_q <= '0;
			end else if (below_floor) begin
				level_q <= LEVEL_START;
				stage_q <= stage_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			samp_a_q <= req.sample_first;
			samp_b_q <= req.sample_second;
		end
		if (state_q == ST_SQ_B) begin
			first_q <= prod[PROD_W-1 -: SAMPLE_W];
		end
		if (done) begin
			out_first_q  <= audible ? first_q : '0;
			out_second_q <= audible ? prod[PROD_W-1 -: SAMPLE_W] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.out_first  = out_first_q;
	assign rsp.out_second = out_second_q;

	a_trigger_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.req_type == REQ_TRIGGER) |=>
		(level_q == LEVEL_START && stage_q == STAGE_FIRST))
		else $error("Trigger did not load the start level and first stage.");

	a_idle_clears_level: assert property (@(posedge clk) disable iff (!arst_n)
		(done && stage_q == STAGE_IDLE) |=> (level_q == '0 && stage_q == STAGE_IDLE))
		else $error("Idle stage did not clear the level.");

	a_stage_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(done && stage_q != STAGE_IDLE && below_floor) |=>
		(stage_q == $past(stage_q) + 3'd1 && level_q == LEVEL_START))
		else $error("Stage did not advance with a level reload.");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_OUT)
		else $error("Result appeared outside the output step.");

endmodule

/* hdl/multi_burst_clap_envelope_top.sv */
// Top level of the multi-burst clap envelope: APB registers, sequencer and shared multiplier.
// Depends on mbce_pkg, mbce_if, mbce_regs, mbce_mul and mbce_ctrl.
//
// A sample pair steps through ST_SQ_A, ST_SC_A, ST_SQ_B, ST_SC_B and ST_OUT, which loads the
// output register: the one 16 by 16 multiplier is used four times in turn, squaring the level
// and scaling the sample for each half of the pair. A trigger transaction gives no result. The
// request channel is ready again as soon as the result sits in the output register; the next
// pair is taken while that result waits, and stalls only at its own output step.
module multi_burst_clap_envelope_top
	import mbce_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	mbce_req_if.sink           req,
	mbce_rsp_if.source         rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	rates_t                   rates;
	mul_req_t                 mul_req;
	logic signed [PROD_W-1:0] prod;

	mbce_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.rates   (rates)
	);

	mbce_mul u_mul (
		.clk     (clk),
		.mul_req (mul_req),
		.prod    (prod)
	);

	mbce_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.rates   (rates),
		.mul_req (mul_req),
		.prod    (prod)
	);

endmodule

/* bench/multi_burst_clap_envelope_top_test.sv */
// Self-checking bench for the multi-burst clap envelope: directed corners, then random claps.
// An envelope_checker object tracks level and stage per transaction and compares every pair.
// Depends on mbce_pkg, mbce_if and the multi_burst_clap_envelope_top RTL.

class envelope_checker;
	logic [30:0] burst_rate;
	logic [30:0] gap_rate;
	logic [31:0] level;
	logic [2:0]  stage;
	logic [31:0] expected_pairs[$];
	int          errors;
	int          pairs_checked;
	logic [7:0]  stages_seen;

	function new();
		burst_rate = '0;
		gap_rate = '0;
		level = '0;
		stage = mbce_pkg::STAGE_IDLE;
		errors = 0;
		pairs_checked = 0;
		stages_seen = '0;
	endfunction

	function void set_rate(logic sel, logic [30:0] value);
		if (sel == mbce_pkg::REG_BURST) begin
			burst_rate = value;
		end else begin
			gap_rate = value;
		end
	endfunction

	function logic signed [15:0] envelope_scale(logic [31:0] lvl, logic signed [15:0] x);
		logic signed [15:0] h;
		logic signed [15:0] g;
		logic signed [31:0] hh;
		logic signed [31:0] p;
		logic [31:0]        sq;
		h = lvl[31:16];
		hh = h * h;
		sq = {hh[30:0], 1'b0};
		g = sq[31:16];
		p = g * x;
		return p[31:16];
	endfunction

	function void note_request(logic kind, logic signed [15:0] a, logic signed [15:0] b);
		logic [31:0]        rate;
		logic               audible;
		logic signed [15:0] oa;
		logic signed [15:0] ob;
		if (kind == mbce_pkg::REQ_TRIGGER) begin
			level = mbce_pkg::LEVEL_START;
			stage = mbce_pkg::STAGE_FIRST;
			return;
		end
		stages_seen[stage] = 1'b1;
		if (stage == mbce_pkg::STAGE_IDLE) begin
			level = '0;
			expected_pairs.push_back(32'd0);
			return;
		end
		if (stage == mbce_pkg::STAGE_TAIL) begin
			rate = {1'b0, burst_rate / 31'd3};
			audible = 1'b1;
		end else if (stage[0]) begin
			rate = {1'b0, gap_rate};
			audible = 1'b0;
		end else begin
			rate = {1'b0, burst_rate};
			audible = 1'b1;
		end
		level = level - rate;
		oa = audible ? envelope_scale(level, a) : 16'sd0;
		level = level - rate;
		ob = audible ? envelope_scale(level, b) : 16'sd0;
		if ($signed(level) < $signed(mbce_pkg::LEVEL_FLOOR)) begin
			stage = stage + 3'd1;
			level = mbce_pkg::LEVEL_START;
		end
		expected_pairs.push_back({oa, ob});
	endfunction

	task report_mismatch(string what);
		errors++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	task check_pair(logic signed [15:0] a, logic signed [15:0] b);
		logic [31:0] want;
		if (expected_pairs.size() == 0) begin
			report_mismatch($sformatf("result %h %h arrived with nothing pending", a, b));
			return;
		end
		want = expected_pairs.pop_front();
		pairs_checked++;
		if (a !== want[31:16])
			report_mismatch($sformatf("out_first %h, expected %h", a, want[31:16]));
		if (b !== want[15:0])
			report_mismatch($sformatf("out_second %h, expected %h", b, want[15:0]));
	endtask
endclass

module multi_burst_clap_envelope_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import mbce_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	mbce_req_if req_ch();
	mbce_rsp_if rsp_ch();

	envelope_checker sb = new();

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int requests_sent = 0;
	int triggers_sent = 0;
	int settings_applied = 0;

	multi_burst_clap_envelope_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #4 clk = ~clk;

	initial begin
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_SAMPLES;
		req_ch.sample_first = '0;
		req_ch.sample_second = '0;
		rsp_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_pair(rsp_ch.out_first, rsp_ch.out_second);
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_request(input logic kind, input logic signed [15:0] a,
		input logic signed [15:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.sample_first <= a;
		req_ch.sample_second <= b;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(kind, a, b);
		requests_sent++;
		if (kind == REQ_TRIGGER)
			triggers_sent++;
	endtask

	task automatic send_pair(input logic signed [15:0] a, input logic signed [15:0] b);
		send_request(REQ_SAMPLES, a, b);
	endtask

	task automatic send_trigger();
		send_request(REQ_TRIGGER, 16'($urandom), 16'($urandom));
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		while (sb.expected_pairs.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input logic sel, input logic [30:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= {1'b0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_rate(sel, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic read_check(input logic sel, input logic [30:0] value);
		logic [PDATA_W-1:0] data;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {sel, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (data !== {1'b0, value})
			sb.report_mismatch($sformatf("register %0d reads %h, expected %h", sel, data,
				{1'b0, value}));
	endtask

	task automatic apply_rates(input logic [30:0] burst, input logic [30:0] gap);
		write_reg(REG_BURST, burst);
		write_reg(REG_GAP, gap);
		read_check(REG_BURST, burst);
		read_check(REG_GAP, gap);
		settings_applied++;
	endtask

	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return 16'shffff;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The second burst decrement lands on 0x80000000, the full-scale square.
		apply_rates(31'h7fff_8000, 31'h4000_0000);
		send_pair(16'sh7fff, 16'sh8000);
		send_trigger();
		send_pair(16'sh8000, 16'sh7fff);
		send_pair(16'sh7fff, 16'sh7fff);
		send_pair(16'sh8000, 16'sh8000);
		send_pair(16'sh0001, 16'shffff);
		send_pair(16'sh7fff, 16'sh8000);
		send_pair(16'sh1234, 16'shedcb);
		repeat (3) send_pair(16'sh7fff, 16'sh8000);
		send_pair(16'sh7fff, 16'sh7fff);
		settle();

		// Maximum burst rate wraps the level back to a large positive value.
		apply_rates(31'h7fff_ffff, 31'h0);
		send_trigger();
		send_pair(16'sh8000, 16'sh7fff);
		send_pair(16'sh0001, 16'shffff);
		send_trigger();
		send_pair(16'sh7fff, 16'sh8000);
		settle();

		apply_rates(31'h7fff_8000, 31'h7fff_ffff);
		send_trigger();
		repeat (3) send_pair(16'sh7fff, 16'sh8000);
		settle();

		apply_rates(31'h0, 31'h0);
		send_trigger();
		send_pair(16'sh8000, 16'sh8000);
		send_pair(16'sh7fff, 16'sh0000);
		settle();

		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
				default: begin send_idle_pct = 19; recv_stall_pct = 19; end
			endcase
			if (phase == 7)
				apply_rates(31'($urandom), 31'($urandom));
			else
				apply_rates(31'($urandom_range(32'h0400_0000, 32'h4000_0000)),
					31'($urandom_range(32'h0400_0000, 32'h4000_0000)));
			send_trigger();
			for (int n = 1; n < 78; n++) begin
				if ($urandom_range(99) == 0)
					send_trigger();
				else
					send_pair(pick_sample(), pick_sample());
			end
			settle();
		end

		$display("Sent %0d requests (%0d triggers) over %0d rate settings.",
			requests_sent, triggers_sent, settings_applied);
		$display("Checked %0d enveloped pairs; stages exercised mask %b.",
			sb.pairs_checked, sb.stages_seen);
		if (sb.errors == 0) begin
			$display("** multi_burst_clap_envelope_top: PASSED **");
		end else begin
			$display("** multi_burst_clap_envelope_top: FAILED **");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timed out with %0d pairs still pending.", sb.expected_pairs.size());
		$display("** multi_burst_clap_envelope_top: FAILED **");
		$finish;
	end
endmodule
